// File: hw/rtl/lcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared types and constants of the LFU cache policy block.
// ----------------------------------------------------------------------------
package lcp_pkg;

	localparam int CAP_W   = 5;
	localparam int COUNT_W = 16;
	localparam int STAMP_W = 48;

	localparam logic [CAP_W-1:0]   CAP_RESET   = 5'd16;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;
	localparam logic [STAMP_W-1:0] STAMP_RESET = 48'd1;

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	// flags that travel with a lookup probe down the cell chain
	typedef struct packed {
		logic valid;
		logic hit;
		logic free_found;
		logic min_found;
	} probe_flags_t;

	// entry update broadcast to all cells
	typedef struct packed {
		logic en;
		logic fill;
		logic set_value;
	} upd_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} lcp_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/lcp_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcp_cell
// One cache entry; checks a passing probe against its entry and hands the
// updated probe to the next cell.
// ----------------------------------------------------------------------------
module lcp_cell
	import lcp_pkg::*;
#(
	parameter int IDX_W      = 4,
	parameter int CELL_IDX   = 0,
	parameter int KEY_BITS   = 16,
	parameter int VALUE_BITS = 32
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  probe_flags_t           in_flags,
	input  wire [KEY_BITS-1:0]     in_key,
	input  wire [IDX_W-1:0]        in_hit_idx,
	input  wire [VALUE_BITS-1:0]   in_hit_val,
	input  wire [IDX_W-1:0]        in_free_idx,
	input  wire [IDX_W-1:0]        in_min_idx,
	input  wire [COUNT_W-1:0]      in_min_cnt,
	input  wire [STAMP_W-1:0]      in_min_stamp,
	input  wire [KEY_BITS-1:0]     in_min_key,
	output probe_flags_t           out_flags,
	output logic [KEY_BITS-1:0]    out_key,
	output logic [IDX_W-1:0]       out_hit_idx,
	output logic [VALUE_BITS-1:0]  out_hit_val,
	output logic [IDX_W-1:0]       out_free_idx,
	output logic [IDX_W-1:0]       out_min_idx,
	output logic [COUNT_W-1:0]     out_min_cnt,
	output logic [STAMP_W-1:0]     out_min_stamp,
	output logic [KEY_BITS-1:0]    out_min_key,
	input  upd_ctl_t               upd,
	input  wire [IDX_W-1:0]        upd_idx,
	input  wire [KEY_BITS-1:0]     upd_key,
	input  wire [VALUE_BITS-1:0]   upd_value,
	input  wire [STAMP_W-1:0]      upd_stamp
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic                  ent_valid_q;
	logic [KEY_BITS-1:0]   ent_key_q;
	logic [VALUE_BITS-1:0] ent_value_q;
	logic [COUNT_W-1:0]    ent_cnt_q;
	logic [STAMP_W-1:0]    ent_stamp_q;

	probe_flags_t          flags_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [VALUE_BITS-1:0] hit_val_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic [IDX_W-1:0]      min_idx_q;
	logic [COUNT_W-1:0]    min_cnt_q;
	logic [STAMP_W-1:0]    min_stamp_q;
	logic [KEY_BITS-1:0]   min_key_q;

	logic match;
	logic take_free;
	logic take_min;
	logic upd_me;

	always_comb begin
		match     = ent_valid_q && (ent_key_q == in_key) && !in_flags.hit;
		take_free = !ent_valid_q && !in_flags.free_found;
		take_min  = ent_valid_q && (!in_flags.min_found || (ent_cnt_q < in_min_cnt) ||
			((ent_cnt_q == in_min_cnt) && (ent_stamp_q < in_min_stamp)));
		upd_me    = upd.en && (upd_idx == MY_IDX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			ent_valid_q <= 1'b0;
		end else begin
			flags_q.valid      <= in_flags.valid;
			flags_q.hit        <= in_flags.hit | match;
			flags_q.free_found <= in_flags.free_found | take_free;
			flags_q.min_found  <= in_flags.min_found | take_min;
			if (upd_me && upd.fill) begin
				ent_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q       <= in_key;
		hit_idx_q   <= match ? MY_IDX : in_hit_idx;
		hit_val_q   <= match ? ent_value_q : in_hit_val;
		free_idx_q  <= take_free ? MY_IDX : in_free_idx;
		min_idx_q   <= take_min ? MY_IDX : in_min_idx;
		min_cnt_q   <= take_min ? ent_cnt_q : in_min_cnt;
		min_stamp_q <= take_min ? ent_stamp_q : in_min_stamp;
		min_key_q   <= take_min ? ent_key_q : in_min_key;
		if (upd_me) begin
			ent_stamp_q <= upd_stamp;
			if (upd.fill) begin
				ent_key_q   <= upd_key;
				ent_value_q <= upd_value;
				ent_cnt_q   <= COUNT_W'(1);
			end else begin
				if (ent_cnt_q != COUNT_MAX) begin
					ent_cnt_q <= ent_cnt_q + COUNT_W'(1);
				end
				if (upd.set_value) begin
					ent_value_q <= upd_value;
				end
			end
		end
	end

	assign out_flags     = flags_q;
	assign out_key       = key_q;
	assign out_hit_idx   = hit_idx_q;
	assign out_hit_val   = hit_val_q;
	assign out_free_idx  = free_idx_q;
	assign out_min_idx   = min_idx_q;
	assign out_min_cnt   = min_cnt_q;
	assign out_min_stamp = min_stamp_q;
	assign out_min_key   = min_key_q;

endmodule
`default_nettype wire

// File: hw/rtl/lcp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcp_ctrl
// Sequencer: injects probes, decides hit, fill or eviction, drives updates
// and holds the result register.
// ----------------------------------------------------------------------------
module lcp_ctrl
	import lcp_pkg::*;
#(
	parameter int MAX_ENTRIES = 16,
	parameter int IDX_W       = 4,
	parameter int KEY_BITS    = 16,
	parameter int VALUE_BITS  = 32,
	parameter int IN_W        = 48,
	parameter int OUT_W       = 56
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire [CAP_W-1:0]       cfg_wdata,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire [IN_W-1:0]        s_tdata,
	input  wire                   s_tuser,
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [OUT_W-1:0]      m_tdata,
	output probe_flags_t          inj_flags,
	output logic [KEY_BITS-1:0]   inj_key,
	input  probe_flags_t          tail_flags,
	input  wire [IDX_W-1:0]       tail_hit_idx,
	input  wire [VALUE_BITS-1:0]  tail_hit_val,
	input  wire [IDX_W-1:0]       tail_free_idx,
	input  wire [IDX_W-1:0]       tail_min_idx,
	input  wire [KEY_BITS-1:0]    tail_min_key,
	output upd_ctl_t              upd,
	output logic [IDX_W-1:0]      upd_idx,
	output logic [KEY_BITS-1:0]   upd_key,
	output logic [VALUE_BITS-1:0] upd_value,
	output logic [STAMP_W-1:0]    upd_stamp
);

	localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
	localparam int RES_W = 2 + VALUE_BITS + KEY_BITS;

	lcp_state_t state_q, state_d;

	logic [CAP_W-1:0]      cap_q;
	logic [STAMP_W-1:0]    clock_q;
	logic [OCC_W-1:0]      occ_q;
	logic                  mode_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	probe_flags_t          res_flags_q;
	logic [IDX_W-1:0]      res_hit_idx_q;
	logic [VALUE_BITS-1:0] res_hit_val_q;
	logic [IDX_W-1:0]      res_free_idx_q;
	logic [IDX_W-1:0]      res_min_idx_q;
	logic [KEY_BITS-1:0]   res_min_key_q;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_data_q;

	logic                  accept;
	logic                  out_free;
	logic [OCC_W-1:0]      cap_eff;
	logic                  do_fill;
	logic                  do_evict;
	logic                  found;
	logic [VALUE_BITS-1:0] read_value;
	logic [KEY_BITS-1:0]   evicted_key;
	logic [RES_W-1:0]      res_word;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		cap_eff = (32'(cap_q) > 32'(MAX_ENTRIES)) ? OCC_W'(MAX_ENTRIES) : OCC_W'(cap_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_d = ST_SCAN;
			ST_SCAN:   if (tail_flags.valid) state_d = ST_COMMIT;
			ST_COMMIT: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready          = (state_q == ST_IDLE);
		inj_flags         = '0;
		inj_flags.valid   = accept;
		inj_key           = s_tdata[KEY_BITS-1:0];
		found             = res_flags_q.hit;
		do_fill           = !res_flags_q.hit && (mode_q == MODE_PUT) &&
			(cap_eff != '0) && (occ_q < cap_eff) && res_flags_q.free_found;
		do_evict          = !res_flags_q.hit && (mode_q == MODE_PUT) &&
			(cap_eff != '0) && (occ_q >= cap_eff) && res_flags_q.min_found;
		read_value        = (found && (mode_q == MODE_GET)) ? res_hit_val_q : '0;
		evicted_key       = do_evict ? res_min_key_q : '0;
		upd               = '0;
		upd.en            = (state_q == ST_COMMIT) && out_free &&
			(found || do_fill || do_evict);
		upd.fill          = !found;
		upd.set_value     = (mode_q == MODE_PUT);
		upd_idx           = found ? res_hit_idx_q : (do_fill ? res_free_idx_q : res_min_idx_q);
		upd_key           = key_q;
		upd_value         = val_q;
		upd_stamp         = clock_q;
		res_word          = {evicted_key, do_evict, read_value, found};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			clock_q     <= STAMP_RESET;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (upd.en) begin
				clock_q <= clock_q + STAMP_W'(1);
			end
			if (upd.en && do_fill) begin
				occ_q <= occ_q + OCC_W'(1);
			end
			if ((state_q == ST_COMMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= s_tuser;
			key_q  <= s_tdata[KEY_BITS-1:0];
			val_q  <= s_tdata[KEY_BITS +: VALUE_BITS];
		end
		if (tail_flags.valid) begin
			res_flags_q    <= tail_flags;
			res_hit_idx_q  <= tail_hit_idx;
			res_hit_val_q  <= tail_hit_val;
			res_free_idx_q <= tail_free_idx;
			res_min_idx_q  <= tail_min_idx;
			res_min_key_q  <= tail_min_key;
		end
		if ((state_q == ST_COMMIT) && out_free) begin
			out_data_q <= OUT_W'(res_word);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail_flags.valid |-> (state_q == ST_SCAN))
		else $error("probe left the chain outside a scan");
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= 32'(MAX_ENTRIES))
		else $error("occupancy above table size");
	a_upd_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		upd.en |=> (out_valid_q && (state_q == ST_IDLE)))
		else $error("entry update without a result");
	a_clock_step: assert property (@(posedge clk) disable iff (!arst_n)
		!upd.en |=> $stable(clock_q))
		else $error("access clock moved without a touch");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/lfu_cache_policy_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cache_policy_top
// Fully associative key-value cache with LFU replacement and LRU tie-break.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: tuser is the mode (0 get, 1 put), tdata
// carries key and value. One response per request leaves on the m_ stream
// with found, read value, evicted flag and evicted key.
// Each entry sits in one cell of a chain; a request probes the chain one cell
// per cycle, collecting the hit, the first free entry and the entry with the
// lowest (use count, stamp). One request is in flight at a time: it passes
// every cell of the chain, is committed to the response register, and only
// then is the next request taken.
// The response register parts the two sides: a new request is accepted while
// a response waits; a stalled receiver holds the commit of the following one.
// cfg_we writes capacity (values above MAX_ENTRIES act as MAX_ENTRIES) and must
// be used only while the block is idle; the block does not enforce it. Reset
// empties the cache, sets capacity to 16 and the access clock to one.
// ----------------------------------------------------------------------------
module lfu_cache_policy_top
	import lcp_pkg::*;
#(
	parameter int MAX_ENTRIES = 16,
	parameter int KEY_BITS    = 16,
	parameter int VALUE_BITS  = 32,
	localparam int IN_W  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 + KEY_BITS + VALUE_BITS + 7) / 8) * 8
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire [CAP_W-1:0]  cfg_wdata,
	input  wire              s_tvalid,
	output logic             s_tready,
	input  wire [IN_W-1:0]   s_tdata,   // key, value
	input  wire              s_tuser,   // mode
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [OUT_W-1:0] m_tdata    // found, read_value, evicted, evicted_key
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	probe_flags_t          p_flags     [MAX_ENTRIES+1];
	logic [KEY_BITS-1:0]   p_key       [MAX_ENTRIES+1];
	logic [IDX_W-1:0]      p_hit_idx   [MAX_ENTRIES+1];
	logic [VALUE_BITS-1:0] p_hit_val   [MAX_ENTRIES+1];
	logic [IDX_W-1:0]      p_free_idx  [MAX_ENTRIES+1];
	logic [IDX_W-1:0]      p_min_idx   [MAX_ENTRIES+1];
	logic [COUNT_W-1:0]    p_min_cnt   [MAX_ENTRIES+1];
	logic [STAMP_W-1:0]    p_min_stamp [MAX_ENTRIES+1];
	logic [KEY_BITS-1:0]   p_min_key   [MAX_ENTRIES+1];

	upd_ctl_t              upd;
	logic [IDX_W-1:0]      upd_idx;
	logic [KEY_BITS-1:0]   upd_key;
	logic [VALUE_BITS-1:0] upd_value;
	logic [STAMP_W-1:0]    upd_stamp;

	assign p_hit_idx[0]   = '0;
	assign p_hit_val[0]   = '0;
	assign p_free_idx[0]  = '0;
	assign p_min_idx[0]   = '0;
	assign p_min_cnt[0]   = '0;
	assign p_min_stamp[0] = '0;
	assign p_min_key[0]   = '0;

	lcp_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.IDX_W       (IDX_W),
		.KEY_BITS    (KEY_BITS),
		.VALUE_BITS  (VALUE_BITS),
		.IN_W        (IN_W),
		.OUT_W       (OUT_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.inj_flags     (p_flags[0]),
		.inj_key       (p_key[0]),
		.tail_flags    (p_flags[MAX_ENTRIES]),
		.tail_hit_idx  (p_hit_idx[MAX_ENTRIES]),
		.tail_hit_val  (p_hit_val[MAX_ENTRIES]),
		.tail_free_idx (p_free_idx[MAX_ENTRIES]),
		.tail_min_idx  (p_min_idx[MAX_ENTRIES]),
		.tail_min_key  (p_min_key[MAX_ENTRIES]),
		.upd           (upd),
		.upd_idx       (upd_idx),
		.upd_key       (upd_key),
		.upd_value     (upd_value),
		.upd_stamp     (upd_stamp)
	);

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		lcp_cell #(
			.IDX_W      (IDX_W),
			.CELL_IDX   (i),
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.in_flags      (p_flags[i]),
			.in_key        (p_key[i]),
			.in_hit_idx    (p_hit_idx[i]),
			.in_hit_val    (p_hit_val[i]),
			.in_free_idx   (p_free_idx[i]),
			.in_min_idx    (p_min_idx[i]),
			.in_min_cnt    (p_min_cnt[i]),
			.in_min_stamp  (p_min_stamp[i]),
			.in_min_key    (p_min_key[i]),
			.out_flags     (p_flags[i+1]),
			.out_key       (p_key[i+1]),
			.out_hit_idx   (p_hit_idx[i+1]),
			.out_hit_val   (p_hit_val[i+1]),
			.out_free_idx  (p_free_idx[i+1]),
			.out_min_idx   (p_min_idx[i+1]),
			.out_min_cnt   (p_min_cnt[i+1]),
			.out_min_stamp (p_min_stamp[i+1]),
			.out_min_key   (p_min_key[i+1]),
			.upd           (upd),
			.upd_idx       (upd_idx),
			.upd_key       (upd_key),
			.upd_value     (upd_value),
			.upd_stamp     (upd_stamp)
		);
	end

endmodule
`default_nettype wire

// File: test/lfu_cache_policy_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_policy_top_tb
// Self-checking bench for the LFU cache with LRU tie-break.
// ----------------------------------------------------------------------------
// Requests come from a queue filled in phases, one capacity setting per phase.
// Each response is checked against a behavioural cache kept in the bench.
// Both sides idle at random. Capacity is written only once the block is
// drained and the extra latency has passed.
// ----------------------------------------------------------------------------
module lfu_cache_policy_top_tb;
	import lcp_pkg::*;

	localparam int ENTRIES = 16;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 56;
	localparam int DRAIN   = 3 * ENTRIES + 10;
	localparam int LIMIT   = 2000000;

	typedef struct packed {
		logic        mode;
		logic [15:0] key;
		logic [31:0] value;
	} request_t;

	typedef struct packed {
		logic        found;
		logic [31:0] read_value;
		logic        evicted;
		logic [15:0] evicted_key;
	} response_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	lfu_cache_policy_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata),   // key, value
		.s_tuser(s_tuser),   // mode
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata)    // found, read_value, evicted, evicted_key
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// bench copy of the cache
	logic              line_valid [ENTRIES];
	logic [15:0]       line_key   [ENTRIES];
	logic [31:0]       line_value [ENTRIES];
	logic [COUNT_W-1:0] line_count [ENTRIES];
	logic [STAMP_W-1:0] line_stamp [ENTRIES];
	logic [STAMP_W-1:0] access_clock;
	int                occupancy;
	int                capacity;

	request_t  pending_requests[$];
	response_t expected_responses[$];
	int        errors = 0;
	int        cycles = 0;
	bit        hold_sender = 1'b0;
	logic [15:0] key_pool[$];

	function automatic void reset_cache();
		for (int i = 0; i < ENTRIES; i++) line_valid[i] = 1'b0;
		access_clock = STAMP_RESET;
		occupancy = 0;
		capacity = CAP_RESET;
	endfunction

	function automatic void refresh_line(int i);
		if (line_count[i] != COUNT_MAX) line_count[i]++;
		line_stamp[i] = access_clock;
		access_clock++;
	endfunction

	function automatic response_t cache_access(request_t rq);
		response_t rsp;
		int hit;
		int slot;
		int cap;
		rsp = '0;
		hit = -1;
		slot = -1;
		cap = (capacity > ENTRIES) ? ENTRIES : capacity;
		for (int i = 0; i < ENTRIES && hit < 0; i++)
			if (line_valid[i] && line_key[i] == rq.key) hit = i;
		if (hit >= 0) begin
			rsp.found = 1'b1;
			if (rq.mode == MODE_GET) rsp.read_value = line_value[hit];
			else line_value[hit] = rq.value;
			refresh_line(hit);
			return rsp;
		end
		if (rq.mode == MODE_GET || cap == 0) return rsp;
		if (occupancy < cap) begin
			for (int i = 0; i < ENTRIES && slot < 0; i++)
				if (!line_valid[i]) slot = i;
			if (slot < 0) return rsp;
			occupancy++;
		end else begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (!line_valid[i]) continue;
				if (slot < 0 || line_count[i] < line_count[slot] ||
				    (line_count[i] == line_count[slot] &&
				     line_stamp[i] < line_stamp[slot]))
					slot = i;
			end
			if (slot < 0) return rsp;
			rsp.evicted = 1'b1;
			rsp.evicted_key = line_key[slot];
		end
		line_valid[slot] = 1'b1;
		line_key[slot] = rq.key;
		line_value[slot] = rq.value;
		line_count[slot] = '0;
		refresh_line(slot);
		return rsp;
	endfunction

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [15:0] pick_key();
		if (key_pool.size() != 0 && $urandom_range(0, 9) < 8)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		return 16'($urandom);
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_responses.push_back(
					cache_access(request_t'({s_tuser, s_tdata[15:0], s_tdata[47:16]})));
				void'(pending_requests.pop_front());
				send_gap = idle_gap();
			end
			if (s_tvalid && !s_tready) begin
				// hold the transaction
			end else if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (!hold_sender && pending_requests.size() != 0) begin
				request_t nx;
				nx = pending_requests[0];
				s_tvalid <= 1'b1;
				s_tuser  <= nx.mode;
				s_tdata  <= {nx.value, nx.key};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	int recv_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (m_tvalid && m_tready) begin
				response_t got;
				response_t exp;
				got = {m_tdata[0], m_tdata[32:1], m_tdata[33], m_tdata[49:34]};
				if (expected_responses.size() == 0) begin
					$error("response with nothing expected");
					errors++;
				end else begin
					exp = expected_responses.pop_front();
					if (got.found !== exp.found) begin
						$error("found: expected %0h, got %0h", exp.found, got.found);
						errors++;
					end
					if (got.read_value !== exp.read_value) begin
						$error("read_value: expected %0h, got %0h",
						       exp.read_value, got.read_value);
						errors++;
					end
					if (got.evicted !== exp.evicted) begin
						$error("evicted: expected %0h, got %0h", exp.evicted, got.evicted);
						errors++;
					end
					if (got.evicted_key !== exp.evicted_key) begin
						$error("evicted_key: expected %0h, got %0h",
						       exp.evicted_key, got.evicted_key);
						errors++;
					end
				end
				recv_gap = idle_gap();
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 9) != 0);
			end
			if (cycles > LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic queue_request(logic mode, logic [15:0] key, logic [31:0] value);
		request_t rq;
		rq.mode = mode;
		rq.key = key;
		rq.value = value;
		pending_requests.push_back(rq);
		if (mode == MODE_PUT) key_pool.push_back(key);
	endtask

	task automatic drain();
		wait (pending_requests.size() == 0 && !s_tvalid);
		wait (expected_responses.size() == 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_capacity(int cap);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= CAP_W'(cap);
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity = cap;
		key_pool.delete();
	endtask

	task automatic random_phase(int n, int key_span);
		for (int i = 0; i < n; i++) begin
			logic [15:0] k;
			k = (key_span > 0) ? 16'($urandom_range(0, key_span)) : pick_key();
			queue_request(logic'($urandom_range(0, 1)), k, $urandom);
		end
	endtask

	initial begin
		int caps[8];
		caps = '{16, 1, 0, 31, 4, 17, 8, 2};
		reset_cache();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fill, hit, extreme fields, eviction, misses
		queue_request(MODE_GET, 16'h0000, 32'h0);
		queue_request(MODE_PUT, 16'h0000, 32'hFFFF_FFFF);
		queue_request(MODE_PUT, 16'hFFFF, 32'h0000_0000);
		queue_request(MODE_GET, 16'h0000, 32'h1234_5678);
		queue_request(MODE_GET, 16'hFFFF, 32'h0);
		queue_request(MODE_PUT, 16'hFFFF, 32'hA5A5_5A5A);
		queue_request(MODE_GET, 16'hFFFF, 32'h0);
		queue_request(MODE_GET, 16'h5555, 32'hFFFF_FFFF);
		for (int i = 1; i <= 15; i++) queue_request(MODE_PUT, 16'(i * 16'h1111 ^ i), $urandom);
		drain();

		// capacity lowered below occupancy: misses evict and reuse slots
		set_capacity(3);
		queue_request(MODE_PUT, 16'hAAAA, 32'h5555_AAAA);
		queue_request(MODE_PUT, 16'h5555, 32'h1);
		drain();

		for (int p = 0; p < 8; p++) begin
			set_capacity(caps[p]);
			random_phase(140, 0);
			random_phase(80, caps[p] + 5);
			if (p == 3) begin
				drain();
				// pause the sender until every response is back
				hold_sender = 1'b1;
				wait (expected_responses.size() == 0);
				hold_sender = 1'b0;
				random_phase(40, 0);
			end
			drain();
		end
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
